@@ rtl/assert_macros.svh @@
// Assertion macros used by ppsc_ctrl.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked in reset too.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ppsc_pkg.sv @@
// Package for the pure pursuit steering block: widths, constants, codes,
// controller states, command and status structs, CORDIC arctangent table.
// No dependencies.
package ppsc_pkg;

   localparam int DEF_PATH_DEPTH   = 256;
   localparam int DEF_CORDIC_ITERS = 16;
   localparam int DEF_RPM_PER_MPS  = 300;
   localparam int DEF_GRIP_GRAVITY = 3767;

   localparam int DIV_W  = 56;           // dividend / radicand width
   localparam int DEN_W  = 24;           // divisor width
   localparam int ROOT_W = DIV_W / 2;
   localparam int XY_W   = 44;           // CORDIC x, y
   localparam int Z_W    = 33;           // CORDIC angle, rad * 2^29
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic signed [Z_W-1:0] ANG_HALF_PI = 33'sd843314856;
   localparam logic signed [Z_W-1:0] ANG_PI      = 33'sd1686629713;
   localparam logic signed [XY_W-1:0] SINE_GAIN  = 44'sd652032874;
   localparam logic [DEN_W-1:0] MIN_CURV = 24'd105;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LA    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LA    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LA_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SPACE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WHEELBASE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXLE_OFS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TAU       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_STEP  = 3'd7;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CAPTURE, OP_MUL_LA, OP_LA, OP_MUL_IDX, OP_IDX,
      OP_RDMEM, OP_CURV, OP_RDIV, OP_SQRT, OP_RPM, OP_ATAN1, OP_SIN,
      OP_MUL_WB, OP_ATAN2, OP_FILT, OP_FDIV, OP_FINISH
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MUL_LA, S_LA, S_MUL_IDX, S_IDX, S_RDMEM, S_CURV,
      S_RDIV_GO, S_RDIV_W, S_SQRT_GO, S_SQRT_W, S_RPM,
      S_ATAN1_GO, S_ATAN1_W, S_SIN_GO, S_SIN_W, S_MUL_WB,
      S_ATAN2_GO, S_ATAN2_W, S_FILT, S_FDIV_GO, S_FDIV_W, S_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic done;       // a multi-cycle unit finished
      logic straight;   // target y is zero
      logic dt_zero;    // elapsed time is zero
   } stat_type;

   // atan(2^-i) in rad * 2^29
   function automatic logic [31:0] atan_val(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'd421657428;
         5'd1:  v = 32'd248918915;
         5'd2:  v = 32'd131521917;
         5'd3:  v = 32'd66762579;
         5'd4:  v = 32'd33510843;
         5'd5:  v = 32'd16771758;
         5'd6:  v = 32'd8387925;
         5'd7:  v = 32'd4194219;
         5'd8:  v = 32'd2097141;
         5'd9:  v = 32'd1048575;
         5'd10: v = 32'd524288;
         5'd11: v = 32'd262144;
         5'd12: v = 32'd131072;
         5'd13: v = 32'd65536;
         5'd14: v = 32'd32768;
         5'd15: v = 32'd16384;
         5'd16: v = 32'd8192;
         5'd17: v = 32'd4096;
         5'd18: v = 32'd2048;
         5'd19: v = 32'd1024;
         5'd20: v = 32'd512;
         5'd21: v = 32'd256;
         5'd22: v = 32'd128;
         5'd23: v = 32'd64;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/pure_pursuit_steering_control.sv @@
// Pure pursuit steering control. A load beat writes the path tables. A control
// step runs a division on the shared bit-serial divider, the square root, three
// CORDIC passes (skipped when the target y is zero) and a filter division on the
// same divider (skipped when the elapsed time is zero); the block returns to idle
// as the result is raised, ready for the next beat.
// Reset is synchronous, active high: CSRs take defaults, history clears.
module pure_pursuit_steering_control #(
   parameter int PATH_DEPTH   = ppsc_pkg::DEF_PATH_DEPTH,
   parameter int CORDIC_ITERS = ppsc_pkg::DEF_CORDIC_ITERS,
   parameter int RPM_PER_MPS  = ppsc_pkg::DEF_RPM_PER_MPS,
   parameter int GRIP_GRAVITY = ppsc_pkg::DEF_GRIP_GRAVITY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [7:0]                        req_point_index,
   input  logic signed [23:0]                req_point_x,
   input  logic signed [23:0]                req_point_y,
   input  logic signed [23:0]                req_point_curvature,
   input  logic [15:0]                       req_speed,
   input  logic [15:0]                       req_elapsed_us,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [15:0]                rsp_steer_cmd,
   output logic signed [15:0]                rsp_motor_rpm,
   output logic [7:0]                        rsp_target_index,
   output logic                              rsp_straight_ahead,
   input  logic                              csr_write_en,
   input  logic [ppsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   ppsc_pkg::cmd_type  cmd;
   ppsc_pkg::stat_type stat;

   ppsc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_kind(req_kind),
      .req_ready(req_ready), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd)
   );

   ppsc_dp #(
      .PATH_DEPTH(PATH_DEPTH), .CORDIC_ITERS(CORDIC_ITERS),
      .RPM_PER_MPS(RPM_PER_MPS), .GRIP_GRAVITY(GRIP_GRAVITY)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_point_index(req_point_index), .req_point_x(req_point_x),
      .req_point_y(req_point_y), .req_point_curvature(req_point_curvature),
      .req_speed(req_speed), .req_elapsed_us(req_elapsed_us),
      .rsp_steer_cmd(rsp_steer_cmd), .rsp_motor_rpm(rsp_motor_rpm),
      .rsp_target_index(rsp_target_index), .rsp_straight_ahead(rsp_straight_ahead)
   );
endmodule

@@ rtl/ppsc_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ppsc_pkg.
module ppsc_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ppsc_pkg::DIV_W-1:0]      num,
   input  logic [ppsc_pkg::DEN_W-1:0]      den,
   output logic [ppsc_pkg::DIV_W-1:0]      quo,
   output logic                            done
);
   localparam int CW = $clog2(ppsc_pkg::DIV_W + 1);

   logic [ppsc_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [ppsc_pkg::DEN_W:0]   rem_ff, rem_in;
   logic [ppsc_pkg::DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [ppsc_pkg::DEN_W:0]   rem_sh;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[ppsc_pkg::DEN_W-1:0], quo_ff[ppsc_pkg::DIV_W-1]};
      if (start) begin
         quo_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CW'(ppsc_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[ppsc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[ppsc_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;
endmodule

@@ rtl/ppsc_sqrt.sv @@
// Integer square root, two radicand bits per cycle.
// Depends on ppsc_pkg.
module ppsc_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ppsc_pkg::DIV_W-1:0]      value,
   output logic [ppsc_pkg::ROOT_W-1:0]     root,
   output logic                            done
);
   localparam int RW = ppsc_pkg::ROOT_W;
   localparam int CW = $clog2(RW + 1);

   logic [ppsc_pkg::DIV_W-1:0] v_ff, v_in;
   logic [RW+2:0]              rem_ff, rem_in;
   logic [RW-1:0]              root_ff, root_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [RW+2:0]              rem_sh, trial;

   always_comb begin
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[RW:0], v_ff[ppsc_pkg::DIV_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         v_in    = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         v_in   = {v_ff[ppsc_pkg::DIV_W-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

@@ rtl/ppsc_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle: vectoring mode gives
// atan2(y, x), rotation mode gives sin(z). Depends on ppsc_pkg.
module ppsc_cordic #(
   parameter int CORDIC_ITERS = ppsc_pkg::DEF_CORDIC_ITERS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                vector_mode,
   input  logic signed [ppsc_pkg::XY_W-1:0]    x0,
   input  logic signed [ppsc_pkg::XY_W-1:0]    y0,
   input  logic signed [ppsc_pkg::Z_W-1:0]     z0,
   output logic signed [ppsc_pkg::Z_W-1:0]     angle,
   output logic signed [ppsc_pkg::XY_W-1:0]    sine,
   output logic                                done
);
   logic signed [ppsc_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ppsc_pkg::Z_W-1:0]  z_ff, z_in, at;
   logic [4:0] it_ff, it_in;
   logic mode_ff, mode_in, zero_ff, zero_in, neg_ff, neg_in;
   logic busy_ff, busy_in, done_ff, done_in, up;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      it_in = it_ff; mode_in = mode_ff; zero_in = zero_ff; neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      xs = x_ff >>> it_ff;
      ys = y_ff >>> it_ff;
      at = $signed({1'b0, ppsc_pkg::atan_val(it_ff)});
      up = mode_ff ? (y_ff >= 0) : (z_ff < 0);
      if (start) begin
         mode_in = vector_mode;
         it_in   = '0;
         busy_in = 1'b1;
         if (vector_mode) begin
            zero_in = (x0 == 0) && (y0 == 0);
            neg_in  = 1'b0;
            x_in = x0; y_in = y0; z_in = '0;
            // quadrant fold for negative x
            if (x0 < 0) begin
               if (y0 >= 0) begin
                  x_in = y0; y_in = -x0; z_in = ppsc_pkg::ANG_HALF_PI;
               end else begin
                  x_in = -y0; y_in = x0; z_in = -ppsc_pkg::ANG_HALF_PI;
               end
            end
         end else begin
            zero_in = 1'b0;
            neg_in  = 1'b0;
            x_in = ppsc_pkg::SINE_GAIN; y_in = '0; z_in = z0;
            if (z0 > ppsc_pkg::ANG_HALF_PI) begin
               z_in = z0 - ppsc_pkg::ANG_PI; neg_in = 1'b1;
            end else if (z0 < -ppsc_pkg::ANG_HALF_PI) begin
               z_in = z0 + ppsc_pkg::ANG_PI; neg_in = 1'b1;
            end
         end
      end else if (busy_ff) begin
         if (up) begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
         end
         it_in = it_ff + 1'b1;
         if (it_ff == 5'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         it_ff   <= it_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      mode_ff <= mode_in; zero_ff <= zero_in; neg_ff <= neg_in;
   end

   assign angle = zero_ff ? '0 : z_ff;
   assign sine  = neg_ff ? -y_ff : y_ff;
   assign done  = done_ff;
endmodule

@@ rtl/ppsc_ctrl.sv @@
// Sequencer for the pure pursuit block: handshakes and datapath commands.
// Depends on ppsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ppsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ppsc_pkg::stat_type  stat,
   output ppsc_pkg::cmd_type   cmd
);
   ppsc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppsc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = ppsc_pkg::OP_NONE;
      case (state_ff)
         ppsc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind) begin
                  cmd.op   = ppsc_pkg::OP_CAPTURE;
                  state_in = ppsc_pkg::S_MUL_LA;
               end else begin
                  cmd.op = ppsc_pkg::OP_LOAD;
               end
            end
         end
         ppsc_pkg::S_MUL_LA: begin
            cmd.op = ppsc_pkg::OP_MUL_LA; state_in = ppsc_pkg::S_LA;
         end
         ppsc_pkg::S_LA: begin
            cmd.op = ppsc_pkg::OP_LA; state_in = ppsc_pkg::S_MUL_IDX;
         end
         ppsc_pkg::S_MUL_IDX: begin
            cmd.op = ppsc_pkg::OP_MUL_IDX; state_in = ppsc_pkg::S_IDX;
         end
         ppsc_pkg::S_IDX: begin
            cmd.op = ppsc_pkg::OP_IDX; state_in = ppsc_pkg::S_RDMEM;
         end
         ppsc_pkg::S_RDMEM: begin
            cmd.op = ppsc_pkg::OP_RDMEM; state_in = ppsc_pkg::S_CURV;
         end
         ppsc_pkg::S_CURV: begin
            cmd.op = ppsc_pkg::OP_CURV; state_in = ppsc_pkg::S_RDIV_GO;
         end
         ppsc_pkg::S_RDIV_GO: begin
            cmd.op = ppsc_pkg::OP_RDIV; state_in = ppsc_pkg::S_RDIV_W;
         end
         ppsc_pkg::S_RDIV_W: begin
            if (stat.done) state_in = ppsc_pkg::S_SQRT_GO;
         end
         ppsc_pkg::S_SQRT_GO: begin
            cmd.op = ppsc_pkg::OP_SQRT; state_in = ppsc_pkg::S_SQRT_W;
         end
         ppsc_pkg::S_SQRT_W: begin
            if (stat.done) state_in = ppsc_pkg::S_RPM;
         end
         ppsc_pkg::S_RPM: begin
            cmd.op   = ppsc_pkg::OP_RPM;
            state_in = stat.straight ? ppsc_pkg::S_FILT : ppsc_pkg::S_ATAN1_GO;
         end
         ppsc_pkg::S_ATAN1_GO: begin
            cmd.op = ppsc_pkg::OP_ATAN1; state_in = ppsc_pkg::S_ATAN1_W;
         end
         ppsc_pkg::S_ATAN1_W: begin
            if (stat.done) state_in = ppsc_pkg::S_SIN_GO;
         end
         ppsc_pkg::S_SIN_GO: begin
            cmd.op = ppsc_pkg::OP_SIN; state_in = ppsc_pkg::S_SIN_W;
         end
         ppsc_pkg::S_SIN_W: begin
            if (stat.done) state_in = ppsc_pkg::S_MUL_WB;
         end
         ppsc_pkg::S_MUL_WB: begin
            cmd.op = ppsc_pkg::OP_MUL_WB; state_in = ppsc_pkg::S_ATAN2_GO;
         end
         ppsc_pkg::S_ATAN2_GO: begin
            cmd.op = ppsc_pkg::OP_ATAN2; state_in = ppsc_pkg::S_ATAN2_W;
         end
         ppsc_pkg::S_ATAN2_W: begin
            if (stat.done) state_in = ppsc_pkg::S_FILT;
         end
         ppsc_pkg::S_FILT: begin
            cmd.op   = ppsc_pkg::OP_FILT;
            state_in = stat.dt_zero ? ppsc_pkg::S_FINISH : ppsc_pkg::S_FDIV_GO;
         end
         ppsc_pkg::S_FDIV_GO: begin
            cmd.op = ppsc_pkg::OP_FDIV; state_in = ppsc_pkg::S_FDIV_W;
         end
         ppsc_pkg::S_FDIV_W: begin
            if (stat.done) state_in = ppsc_pkg::S_FINISH;
         end
         ppsc_pkg::S_FINISH: begin
            // output register must be free before the result beat is loaded
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = ppsc_pkg::OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = ppsc_pkg::S_IDLE;
            end
         end
         default: state_in = ppsc_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_finish_room, clock, reset, (cmd.op == ppsc_pkg::OP_FINISH) |-> (!rsp_valid_ff || rsp_ready), "result beat loaded over a pending one")
   `ASSERT_CLK(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ppsc_pkg::S_FINISH), "result valid raised outside finish")
   `ASSERT_CLK(a_done_in_wait, clock, reset, stat.done |-> (state_ff == ppsc_pkg::S_RDIV_W || state_ff == ppsc_pkg::S_SQRT_W || state_ff == ppsc_pkg::S_ATAN1_W || state_ff == ppsc_pkg::S_SIN_W || state_ff == ppsc_pkg::S_ATAN2_W || state_ff == ppsc_pkg::S_FDIV_W), "unit done while not waiting")
endmodule

@@ rtl/ppsc_dp.sv @@
// Datapath: CSRs, path point tables, lookahead and index arithmetic, rpm and
// steering filter, with the shared divider, square root and CORDIC units.
// Depends on ppsc_pkg, ppsc_div, ppsc_sqrt, ppsc_cordic.
module ppsc_dp #(
   parameter int PATH_DEPTH   = ppsc_pkg::DEF_PATH_DEPTH,
   parameter int CORDIC_ITERS = ppsc_pkg::DEF_CORDIC_ITERS,
   parameter int RPM_PER_MPS  = ppsc_pkg::DEF_RPM_PER_MPS,
   parameter int GRIP_GRAVITY = ppsc_pkg::DEF_GRIP_GRAVITY
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppsc_pkg::cmd_type                    cmd,
   output ppsc_pkg::stat_type                   stat,
   input  logic                                 csr_write_en,
   input  logic [ppsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppsc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                           req_point_index,
   input  logic signed [23:0]                   req_point_x,
   input  logic signed [23:0]                   req_point_y,
   input  logic signed [23:0]                   req_point_curvature,
   input  logic [15:0]                          req_speed,
   input  logic [15:0]                          req_elapsed_us,
   output logic signed [15:0]                   rsp_steer_cmd,
   output logic signed [15:0]                   rsp_motor_rpm,
   output logic [7:0]                           rsp_target_index,
   output logic                                 rsp_straight_ahead
);
   localparam int AW = $clog2(PATH_DEPTH);
   localparam logic [63:0] RPM_K = 64'(GRIP_GRAVITY) * 64'd4096 *
                                   64'(RPM_PER_MPS) * 64'(RPM_PER_MPS);
   localparam int XW = ppsc_pkg::XY_W;

   // CSRs
   logic [15:0] min_la_ff, max_la_ff, gain_ff, inv_sp_ff, step_ff;
   logic [12:0] wb_ff;
   logic signed [13:0] rao_ff;
   logic [19:0] tau_ff;
   logic signed [15:0] last_steer_ff, last_steer_in, last_rpm_ff, last_rpm_in;

   // path tables
   logic signed [23:0] mem_x [PATH_DEPTH];
   logic signed [23:0] mem_y [PATH_DEPTH];
   logic signed [23:0] mem_c [PATH_DEPTH];
   logic signed [23:0] rd_x_ff, rd_y_ff, rd_c_ff;
   logic [AW+7:0] wr_ext;
   logic [AW-1:0] wr_addr;

   // working registers
   logic [15:0] speed_ff, speed_in, dt_ff, dt_in, la_ff, la_in;
   logic [31:0] prod_ff, prod_in, num_ff, num_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [23:0] c_ff, c_in;
   logic straight_ff, straight_in, neg_ff, neg_in;
   logic signed [24:0] ex_ff, ex_in;
   logic signed [15:0] lim_ff, lim_in;
   logic signed [32:0] wnum_ff, wnum_in;
   logic [20:0] den_ff, den_in;
   logic signed [15:0] out_steer_ff, out_steer_in, out_rpm_ff, out_rpm_in;
   logic [7:0] out_idx_ff, out_idx_in;
   logic out_str_ff, out_str_in;

   // unit hookup
   logic div_start, sqrt_start, cor_start, cor_vec;
   logic [ppsc_pkg::DIV_W-1:0] div_num, div_quo;
   logic [ppsc_pkg::DEN_W-1:0] div_den;
   logic [ppsc_pkg::ROOT_W-1:0] root;
   logic signed [XW-1:0] cor_x0, cor_y0, cor_sine;
   logic signed [ppsc_pkg::Z_W-1:0] cor_angle;
   logic div_done, sqrt_done, cor_done;

   // combinational temporaries
   logic [26:0] la_sum;
   logic [32:0] idx_sum;
   logic [14:0] idx_raw;
   logic [23:0] c_abs;
   logic signed [29:0] delta, step_s, lim30;
   logic signed [47:0] wprod;
   logic signed [33:0] tq34;
   logic signed [15:0] target;
   logic signed [16:0] diff17, abs17, q17, st17;
   logic [32:0] fnum;
   logic [AW+7:0] idx_ext;

   ppsc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .quo(div_quo), .done(div_done)
   );

   ppsc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .value(div_quo),
      .root(root), .done(sqrt_done)
   );

   ppsc_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .vector_mode(cor_vec),
      .x0(cor_x0), .y0(cor_y0), .z0(cor_angle), .angle(cor_angle),
      .sine(cor_sine), .done(cor_done)
   );

   assign stat.done     = div_done | sqrt_done | cor_done;
   assign stat.straight = straight_ff;
   assign stat.dt_zero  = (dt_ff == 16'd0);

   assign wr_ext  = {{AW{1'b0}}, req_point_index};
   assign wr_addr = wr_ext[AW-1:0];
   assign idx_ext = {8'd0, idx_ff};

   // unit operands
   always_comb begin
      div_start  = (cmd.op == ppsc_pkg::OP_RDIV) || (cmd.op == ppsc_pkg::OP_FDIV);
      sqrt_start = (cmd.op == ppsc_pkg::OP_SQRT);
      cor_start  = (cmd.op == ppsc_pkg::OP_ATAN1) || (cmd.op == ppsc_pkg::OP_SIN) ||
                   (cmd.op == ppsc_pkg::OP_ATAN2);
      cor_vec    = (cmd.op != ppsc_pkg::OP_SIN);
      fnum       = {1'b0, num_ff} + {13'd0, den_ff[20:1]};
      if (cmd.op == ppsc_pkg::OP_RDIV) begin
         div_num = RPM_K[ppsc_pkg::DIV_W-1:0];
         div_den = c_ff;
      end else begin
         div_num = {{(ppsc_pkg::DIV_W-33){1'b0}}, fnum};
         div_den = {3'd0, den_ff};
      end
      if (cmd.op == ppsc_pkg::OP_ATAN2) begin
         cor_x0 = {{(XW-32){1'b0}}, la_ff, 16'd0};
         cor_y0 = {{(XW-33){wnum_ff[32]}}, wnum_ff};
      end else begin
         cor_x0 = {{(XW-41){ex_ff[24]}}, ex_ff, 16'd0};
         cor_y0 = {{(XW-40){rd_y_ff[23]}}, rd_y_ff, 16'd0};
      end
   end

   // step arithmetic
   always_comb begin
      speed_in = speed_ff; dt_in = dt_ff; la_in = la_ff; prod_in = prod_ff;
      num_in = num_ff; idx_in = idx_ff; c_in = c_ff; straight_in = straight_ff;
      neg_in = neg_ff; ex_in = ex_ff; lim_in = lim_ff; wnum_in = wnum_ff;
      den_in = den_ff;
      out_steer_in = out_steer_ff; out_rpm_in = out_rpm_ff;
      out_idx_in = out_idx_ff; out_str_in = out_str_ff;
      last_steer_in = last_steer_ff; last_rpm_in = last_rpm_ff;

      la_sum  = {11'd0, min_la_ff} + {1'b0, prod_ff[31:6]};
      idx_sum = {1'b0, prod_ff} + 33'h20000;
      idx_raw = idx_sum[32:18];
      c_abs   = rd_c_ff[23] ? 24'(-rd_c_ff) : 24'(rd_c_ff);
      step_s  = $signed({14'd0, step_ff});
      delta   = $signed({2'b00, root}) - 30'(last_rpm_ff);
      if (delta > step_s) delta = step_s;
      lim30   = 30'(last_rpm_ff) + delta;
      // sine is signed, keep its sign through the widening
      wprod   = $signed({2'b00, wb_ff, 1'b0}) * 48'($signed(cor_sine[32:0]));
      tq34    = 34'(cor_angle) + 34'sd32768;
      target  = straight_ff ? 16'sd0 : tq34[31:16];
      diff17  = 17'(target) - 17'(last_steer_ff);
      abs17   = diff17[16] ? -diff17 : diff17;
      q17     = $signed({1'b0, div_quo[15:0]});
      st17    = 17'(last_steer_ff) + (neg_ff ? -q17 : q17);

      case (cmd.op)
         ppsc_pkg::OP_CAPTURE: begin
            speed_in = req_speed;
            dt_in    = req_elapsed_us;
         end
         ppsc_pkg::OP_MUL_LA: prod_in = gain_ff * speed_ff;
         ppsc_pkg::OP_LA: begin
            // lookahead is min plus the speed term, capped at max; max wins when min exceeds it
            la_in = (la_sum > {11'd0, max_la_ff}) ? max_la_ff : la_sum[15:0];
         end
         ppsc_pkg::OP_MUL_IDX: prod_in = la_ff * inv_sp_ff;
         ppsc_pkg::OP_IDX: begin
            if (32'(idx_raw) > PATH_DEPTH - 1) idx_in = AW'(PATH_DEPTH - 1);
            else idx_in = idx_raw[AW-1:0];
         end
         ppsc_pkg::OP_CURV: begin
            c_in        = (c_abs < ppsc_pkg::MIN_CURV) ? ppsc_pkg::MIN_CURV : c_abs;
            straight_in = (rd_y_ff == 24'sd0);
            ex_in       = 25'(rd_x_ff) - 25'(rao_ff);
         end
         ppsc_pkg::OP_RPM: begin
            lim_in = (lim30 > 30'sd32767) ? 16'sh7fff : lim30[15:0];
         end
         ppsc_pkg::OP_MUL_WB: wnum_in = wprod[46:14];
         ppsc_pkg::OP_FILT: begin
            neg_in = diff17[16];
            num_in = abs17[15:0] * dt_ff;
            den_in = {1'b0, tau_ff} + {5'd0, dt_ff};
         end
         ppsc_pkg::OP_FINISH: begin
            out_steer_in  = (dt_ff == 16'd0) ? last_steer_ff : st17[15:0];
            out_rpm_in    = lim_ff;
            out_idx_in    = idx_ext[7:0];
            out_str_in    = straight_ff;
            last_steer_in = out_steer_in;
            last_rpm_in   = lim_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_la_ff <= 16'd2048;
         max_la_ff <= 16'd10240;
         gain_ff   <= 16'd256;
         inv_sp_ff <= 16'd2560;
         wb_ff     <= 13'd1587;
         rao_ff    <= 14'sd0;
         tau_ff    <= 20'd100000;
         step_ff   <= 16'd100;
         last_steer_ff <= 16'sd0;
         last_rpm_ff   <= 16'sd0;
      end else begin
         last_steer_ff <= last_steer_in;
         last_rpm_ff   <= last_rpm_in;
         if (csr_write_en) begin
            case (csr_index)
               ppsc_pkg::CSR_MIN_LA:    min_la_ff <= csr_wdata[15:0];
               ppsc_pkg::CSR_MAX_LA:    max_la_ff <= csr_wdata[15:0];
               ppsc_pkg::CSR_LA_GAIN:   gain_ff   <= csr_wdata[15:0];
               ppsc_pkg::CSR_INV_SPACE: inv_sp_ff <= csr_wdata[15:0];
               ppsc_pkg::CSR_WHEELBASE: wb_ff     <= csr_wdata[12:0];
               ppsc_pkg::CSR_AXLE_OFS:  rao_ff    <= $signed(csr_wdata[13:0]);
               ppsc_pkg::CSR_TAU:       tau_ff    <= csr_wdata;
               ppsc_pkg::CSR_RPM_STEP:  step_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      speed_ff <= speed_in; dt_ff <= dt_in; la_ff <= la_in; prod_ff <= prod_in;
      num_ff <= num_in; idx_ff <= idx_in; c_ff <= c_in; straight_ff <= straight_in;
      neg_ff <= neg_in; ex_ff <= ex_in; lim_ff <= lim_in; wnum_ff <= wnum_in;
      den_ff <= den_in;
      out_steer_ff <= out_steer_in; out_rpm_ff <= out_rpm_in;
      out_idx_ff <= out_idx_in; out_str_ff <= out_str_in;
   end

   // table write on a load beat, registered read of the target point
   always_ff @(posedge clock) begin
      if (cmd.op == ppsc_pkg::OP_LOAD && 32'(req_point_index) < PATH_DEPTH) begin
         mem_x[wr_addr] <= req_point_x;
         mem_y[wr_addr] <= req_point_y;
         mem_c[wr_addr] <= req_point_curvature;
      end
      if (cmd.op == ppsc_pkg::OP_RDMEM) begin
         rd_x_ff <= mem_x[idx_ff];
         rd_y_ff <= mem_y[idx_ff];
         rd_c_ff <= mem_c[idx_ff];
      end
   end

   assign rsp_steer_cmd      = out_steer_ff;
   assign rsp_motor_rpm      = out_rpm_ff;
   assign rsp_target_index   = out_idx_ff;
   assign rsp_straight_ahead = out_str_ff;
endmodule

@@ tb/tb.sv @@
// Testbench for pure_pursuit_steering_control: queued stimulus, driver and monitor,
// plus a bit-exact predictor of steering, rpm, target index and straight flag per control beat.
// Depends on ppsc_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb;

   localparam int    DEPTH     = 256;
   localparam int    ITERS     = 16;
   localparam longint HALF_PI  = 843314856;
   localparam longint PI_FX    = 1686629713;
   localparam longint SIN_K    = 652032874;
   localparam longint CURV_MIN = 105;
   localparam longint RPM_K    = 64'd3767 * 4096 * 300 * 300;
   localparam int    SETTLE    = 400;
   localparam longint LIMIT    = 3000000;

   typedef struct {
      bit kind;
      logic [7:0] pidx;
      logic signed [23:0] px, py, pc;
      logic [15:0] spd, dt;
   } beat_type;

   typedef struct {
      logic [15:0] steer, rpm;
      logic [7:0] tidx;
      logic straight;
   } ctrl_out_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_kind = 0;
   logic [7:0] req_point_index = 0;
   logic signed [23:0] req_point_x = 0, req_point_y = 0, req_point_curvature = 0;
   logic [15:0] req_speed = 0, req_elapsed_us = 0;
   logic rsp_ready = 0;
   logic csr_write_en = 0;
   logic [ppsc_pkg::CSR_IDX_W-1:0] csr_index = 0;
   logic [ppsc_pkg::CSR_DATA_W-1:0] csr_wdata = 0;
   wire req_ready, rsp_valid, rsp_straight_ahead;
   wire signed [15:0] rsp_steer_cmd, rsp_motor_rpm;
   wire [7:0] rsp_target_index;

   pure_pursuit_steering_control u_dut (.*);

   always #5 clock = ~clock;

   beat_type pend_q[$];
   ctrl_out_type ctrl_exp_q[$];
   int errors = 0;
   longint cycles = 0;
   bit req_taken = 0;

   // predictor state
   longint atan_tab [0:ITERS-1];
   longint tbl_x [0:DEPTH-1], tbl_y [0:DEPTH-1], tbl_c [0:DEPTH-1];
   longint la_min, la_max, la_gain, inv_sp, wb, axle_ofs, tau, rpm_step;
   longint last_steer, last_rpm;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   function automatic longint cordic_atan2(input longint y0, input longint x0);
      longint x, y, z, t, nx;
      x = x0; y = y0; z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = HALF_PI;
         end else begin
            t = x; x = -y; y = t; z = -HALF_PI;
         end
      end
      for (int i = 0; i < ITERS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
         end else begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint cordic_sin(input longint a0);
      longint a, x, y, nx;
      bit neg;
      a = a0; x = SIN_K; y = 0; neg = 0;
      if (a > HALF_PI) begin
         a -= PI_FX; neg = 1;
      end else if (a < -HALF_PI) begin
         a += PI_FX; neg = 1;
      end
      for (int i = 0; i < ITERS; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); a -= atan_tab[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); a += atan_tab[i];
         end
         x = nx;
      end
      return neg ? -y : y;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v0);
      longint unsigned v, r, b;
      v = v0; r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // one accepted beat: loads update the path table, control beats yield a result
   task automatic pursuit_predict(input beat_type b);
      longint la, idx, c, delta, lim, target, steer, diff, num, den, q, a, sn;
      ctrl_out_type o;
      if (!b.kind) begin
         tbl_x[b.pidx] = b.px; tbl_y[b.pidx] = b.py; tbl_c[b.pidx] = b.pc;
         return;
      end
      la = la_min + ((la_gain * b.spd) >> 6);
      if (la < la_min) la = la_min;
      if (la > la_max) la = la_max;
      idx = (la * inv_sp + (64'd1 << 17)) >> 18;
      if (idx > DEPTH - 1) idx = DEPTH - 1;
      c = tbl_c[idx] < 0 ? -tbl_c[idx] : tbl_c[idx];
      if (c < CURV_MIN) c = CURV_MIN;
      delta = longint'(int_sqrt(RPM_K / c)) - last_rpm;
      if (delta > rpm_step) delta = rpm_step;
      lim = last_rpm + delta;
      if (lim > 32767) lim = 32767;
      if (lim < -32768) lim = -32768;
      o.straight = (tbl_y[idx] == 0);
      if (o.straight) target = 0;
      else begin
         a = cordic_atan2(tbl_y[idx] * 65536, (tbl_x[idx] - axle_ofs) * 65536);
         sn = (2 * wb * cordic_sin(a)) >>> 14;
         target = (cordic_atan2(sn, la * 65536) + 32768) >>> 16;
      end
      if (b.dt == 0) steer = last_steer;
      else begin
         diff = target - last_steer;
         den = tau + b.dt;
         num = (diff < 0 ? -diff : diff) * b.dt;
         q = (num + den / 2) / den;
         steer = last_steer + (diff < 0 ? -q : q);
      end
      last_steer = steer;
      last_rpm = lim;
      o.steer = steer[15:0]; o.rpm = lim[15:0]; o.tidx = idx[7:0];
      ctrl_exp_q.push_back(o);
   endtask

   // sampling side: accepted beats, register writes, results, timeout
   always @(posedge clock) begin
      ctrl_out_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("Simulation FAILED");
         $finish;
      end else if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            pursuit_predict('{req_kind, req_point_index, req_point_x, req_point_y,
                              req_point_curvature, req_speed, req_elapsed_us});
         if (csr_write_en) begin
            case (csr_index)
               ppsc_pkg::CSR_MIN_LA:    la_min = csr_wdata[15:0];
               ppsc_pkg::CSR_MAX_LA:    la_max = csr_wdata[15:0];
               ppsc_pkg::CSR_LA_GAIN:   la_gain = csr_wdata[15:0];
               ppsc_pkg::CSR_INV_SPACE: inv_sp = csr_wdata[15:0];
               ppsc_pkg::CSR_WHEELBASE: wb = csr_wdata[12:0];
               ppsc_pkg::CSR_AXLE_OFS:  axle_ofs = longint'($signed(csr_wdata[13:0]));
               ppsc_pkg::CSR_TAU:       tau = csr_wdata[19:0];
               ppsc_pkg::CSR_RPM_STEP:  rpm_step = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (ctrl_exp_q.size() == 0) report("unexpected beat", rsp_steer_cmd, 0);
            else begin
               e = ctrl_exp_q.pop_front();
               if (rsp_steer_cmd !== e.steer)
                  report("steer_cmd", rsp_steer_cmd, $signed(e.steer));
               if (rsp_motor_rpm !== e.rpm)
                  report("motor_rpm", rsp_motor_rpm, $signed(e.rpm));
               if (rsp_target_index !== e.tidx)
                  report("target_index", rsp_target_index, e.tidx);
               if (rsp_straight_ahead !== e.straight)
                  report("straight_ahead", rsp_straight_ahead, e.straight);
            end
         end
      end
   end

   // driver: bursts of beats separated by random gaps
   int gap = 0, burst = 4;
   always @(negedge clock) begin
      beat_type b;
      if (reset) req_valid <= 0;
      else if (req_valid && !req_taken) ;
      else if (gap > 0) begin
         gap--;
         req_valid <= 0;
      end else if (pend_q.size() > 0) begin
         b = pend_q.pop_front();
         req_valid <= 1;
         req_kind <= b.kind; req_point_index <= b.pidx;
         req_point_x <= b.px; req_point_y <= b.py; req_point_curvature <= b.pc;
         req_speed <= b.spd; req_elapsed_us <= b.dt;
         if (--burst <= 0) begin
            burst = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
         end
      end else req_valid <= 0;
   end

   // receiver stall pattern: one of four modes picked at random
   int stall_mode = 0;
   always @(negedge clock) begin
      if (cycles % 100 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((cycles / 7) % 2 == 0);
      endcase
   end

   task automatic push_load(input int i, input int x, input int y, input int c);
      pend_q.push_back('{1'b0, i[7:0], x[23:0], y[23:0], c[23:0], 16'd0, 16'd0});
   endtask

   task automatic push_ctrl(input int s, input int d);
      pend_q.push_back('{1'b1, 8'd0, 24'd0, 24'd0, 24'd0, s[15:0], d[15:0]});
   endtask

   task automatic csr_write(input logic [ppsc_pkg::CSR_IDX_W-1:0] i, input int d);
      @(negedge clock);
      csr_write_en <= 1; csr_index <= i; csr_wdata <= d[ppsc_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   task automatic wait_idle();
      while (pend_q.size() != 0 || req_valid || ctrl_exp_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int rand_field();
      case ($urandom_range(0, 5))
         0: return -8388608;
         1: return 8388607;
         2: return 0;
         3: return $signed($urandom_range(0, 4095)) - 2048;
         default: return $signed($urandom()) >>> 8;
      endcase
   endfunction

   task automatic random_beats(input int n);
      int y, c;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 3) begin
            y = ($urandom_range(0, 9) == 0) ? 0 : rand_field();
            c = ($urandom_range(0, 4) == 0) ? $signed($urandom_range(0, 300)) - 150
                                            : rand_field();
            push_load($urandom_range(0, 255), rand_field(), y, c);
         end else begin
            push_ctrl(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 8000),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      int a, b;
      atan_tab = '{421657428, 248918915, 131521917, 66762579, 33510843, 16771758,
                   8387925, 4194219, 2097141, 1048575, 524288, 262144,
                   131072, 65536, 32768, 16384};
      la_min = 2048; la_max = 10240; la_gain = 256; inv_sp = 2560;
      wb = 1587; axle_ofs = 0; tau = 100000; rpm_step = 100;
      last_steer = 0; last_rpm = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // fill the whole table first so no entry is read unwritten
      for (int i = 0; i < DEPTH; i++) push_load(i, rand_field(), rand_field(), rand_field());
      push_load(20, 5000, 0, 0);                 // straight ahead, minimum curvature
      push_load(100, -3000, 4000, -8388608);     // behind the axle, largest curvature
      push_load(255, 8388607, -8388608, 8388607);
      push_load(0, 0, 0, 0);
      push_ctrl(0, 0);          // held steering
      push_ctrl(0, 1000);
      push_ctrl(65535, 65535);  // lookahead clamped to max
      push_ctrl(65535, 1);
      push_ctrl(12800, 20000);
      push_ctrl(0, 65535);
      random_beats(180);
      wait_idle();

      for (int p = 1; p < 10; p++) begin
         case (p)
            1: begin   // min above max, everything high
               csr_write(ppsc_pkg::CSR_MIN_LA, 65535); csr_write(ppsc_pkg::CSR_MAX_LA, 0);
               csr_write(ppsc_pkg::CSR_LA_GAIN, 65535);
               csr_write(ppsc_pkg::CSR_INV_SPACE, 65535);
               csr_write(ppsc_pkg::CSR_WHEELBASE, 8191);
               csr_write(ppsc_pkg::CSR_AXLE_OFS, 8191);
               csr_write(ppsc_pkg::CSR_TAU, 1048575);
               csr_write(ppsc_pkg::CSR_RPM_STEP, 65535);
            end
            2: begin   // lows, zero tau, target index stays at zero
               csr_write(ppsc_pkg::CSR_MIN_LA, 0); csr_write(ppsc_pkg::CSR_MAX_LA, 65535);
               csr_write(ppsc_pkg::CSR_LA_GAIN, 0); csr_write(ppsc_pkg::CSR_INV_SPACE, 1);
               csr_write(ppsc_pkg::CSR_WHEELBASE, 0);
               csr_write(ppsc_pkg::CSR_AXLE_OFS, -8192);
               csr_write(ppsc_pkg::CSR_TAU, 0); csr_write(ppsc_pkg::CSR_RPM_STEP, 0);
            end
            3: begin
               csr_write(ppsc_pkg::CSR_LA_GAIN, 65535);
               csr_write(ppsc_pkg::CSR_INV_SPACE, 65535);
               csr_write(ppsc_pkg::CSR_WHEELBASE, 8191);
            end
            default: begin
               a = $urandom_range(0, 20000); b = a + $urandom_range(0, 40000);
               csr_write(ppsc_pkg::CSR_MIN_LA, a); csr_write(ppsc_pkg::CSR_MAX_LA, b);
               csr_write(ppsc_pkg::CSR_LA_GAIN, $urandom_range(0, 2000));
               csr_write(ppsc_pkg::CSR_INV_SPACE, $urandom_range(1, 8000));
               csr_write(ppsc_pkg::CSR_WHEELBASE, $urandom_range(0, 8191));
               csr_write(ppsc_pkg::CSR_AXLE_OFS, $signed($urandom_range(0, 16383)) - 8192);
               csr_write(ppsc_pkg::CSR_TAU,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048575)
                                                     : $urandom_range(0, 200000));
               csr_write(ppsc_pkg::CSR_RPM_STEP, $urandom_range(0, 65535));
            end
         endcase
         if (p == 1) push_ctrl(100, 500);
         random_beats(160);
         wait_idle();
      end

      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
